[rtl/core/tgr_pkg.sv]
// Package for the touch gesture recognizer: field widths, scaling constants,
// configuration register indexes, gesture codes and shared structs.
// No dependencies.
package tgr_pkg;

   localparam int MAX_X = 319;
   localparam int MAX_Y = 239;

   localparam int RAW_W  = 10;
   localparam int TIME_W = 32;
   localparam int X_W    = 9;
   localparam int Y_W    = 8;
   localparam int MS_W   = 16;
   localparam int DRAG_W = 9;

   // Calibration points of the panel
   localparam int RAW_X0 = 170;
   localparam int RAW_X1 = 960;
   localparam int RAW_Y0 = 190;
   localparam int RAW_Y1 = 990;

   // Constant division by reciprocal multiply: q = (a * MUL) >> RECIP_SHIFT
   localparam int RECIP_SHIFT = 24;
   localparam int MUL_W       = 28;
   localparam int PROD_W      = RAW_W + MUL_W;
   localparam int Q_W         = 13;
   localparam longint MUL_Y_L =
      ((longint'(MAX_Y) << RECIP_SHIFT) + longint'(RAW_X1 - RAW_X0) - 64'd1)
      / longint'(RAW_X1 - RAW_X0);
   localparam longint MUL_X_L =
      ((longint'(MAX_X) << RECIP_SHIFT) + longint'(RAW_Y1 - RAW_Y0) - 64'd1)
      / longint'(RAW_Y1 - RAW_Y0);
   localparam logic [MUL_W-1:0] MUL_Y = MUL_W'(MUL_Y_L);
   localparam logic [MUL_W-1:0] MUL_X = MUL_W'(MUL_X_L);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESSURE_THRESHOLD = 3'd0,
      CSR_RELEASE_DELAY      = 3'd1,
      CSR_LONG_PRESS         = 3'd2,
      CSR_DOUBLE_TAP         = 3'd3,
      CSR_DRAG_DISTANCE      = 3'd4
   } tgr_csr_idx_type;

   typedef enum logic [3:0] {
      G_NONE          = 4'd0,
      G_PRESS         = 4'd1,
      G_DOUBLE_PRESS  = 4'd2,
      G_DRAG          = 4'd3,
      G_LONG_DRAG     = 4'd4,
      G_TAP_DRAG      = 4'd5,
      G_LONG_PRESS    = 4'd6,
      G_TAP_LONG      = 4'd7,
      G_TAPPED        = 4'd8,
      G_DOUBLE_TAPPED = 4'd9,
      G_DRAG_REL      = 4'd10,
      G_LONG_REL      = 4'd11,
      G_LONG_DRAG_REL = 4'd12,
      G_TAP_DRAG_REL  = 4'd13,
      G_TAP_LONG_REL  = 4'd14
   } tgr_gesture_type;

   typedef struct packed {
      logic [RAW_W-1:0]  pressure_threshold;
      logic [MS_W-1:0]   release_delay_ms;
      logic [MS_W-1:0]   long_press_ms;
      logic [MS_W-1:0]   double_tap_ms;
      logic [DRAG_W-1:0] drag_distance;
   } tgr_cfg_type;

   // One scaled sample handed from the scaling stage to the tracker
   typedef struct packed {
      logic              touching;
      logic [X_W-1:0]    x;
      logic [Y_W-1:0]    y;
      logic [TIME_W-1:0] time_ms;
   } tgr_sample_type;

endpackage

[rtl/core/tgr_scale.sv]
// Input register and scaling stage: raw panel readings to clamped screen
// coordinates plus the touch decision. Depends on tgr_pkg.
module tgr_scale (
   input  logic                          clock,
   input  logic                          reset,
   input  tgr_pkg::tgr_cfg_type          cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tgr_pkg::RAW_W-1:0]     req_pressure,
   input  logic [tgr_pkg::RAW_W-1:0]     req_raw_x,
   input  logic [tgr_pkg::RAW_W-1:0]     req_raw_y,
   input  logic [tgr_pkg::TIME_W-1:0]    req_time_ms,
   output logic                          smp_valid,
   input  logic                          smp_ready,
   output tgr_pkg::tgr_sample_type       smp
);

   logic                          s1_valid_ff;
   logic [tgr_pkg::RAW_W-1:0]     pressure_ff;
   logic [tgr_pkg::RAW_W-1:0]     raw_x_ff;
   logic [tgr_pkg::RAW_W-1:0]     raw_y_ff;
   logic [tgr_pkg::TIME_W-1:0]    time_ff;
   logic                          s2_valid_ff;
   tgr_pkg::tgr_sample_type       smp_ff;
   tgr_pkg::tgr_sample_type       smp_in;
   logic                          s2_load;

   logic [tgr_pkg::RAW_W-1:0]     ay;
   logic [tgr_pkg::RAW_W-1:0]     ax;
   logic [tgr_pkg::PROD_W-1:0]    prod_y;
   logic [tgr_pkg::PROD_W-1:0]    prod_x;
   logic [tgr_pkg::Q_W-1:0]       q_y;
   logic [tgr_pkg::Q_W-1:0]       q_x;
   logic [tgr_pkg::Q_W-1:0]       y_full;

   assign s2_load   = !s2_valid_ff || smp_ready;
   assign req_ready = !s1_valid_ff || s2_load;

   // Screen y falls as raw x rises; screen x rises with raw y
   always_comb begin
      ay     = raw_x_ff - tgr_pkg::RAW_W'(tgr_pkg::RAW_X0);
      ax     = raw_y_ff - tgr_pkg::RAW_W'(tgr_pkg::RAW_Y0);
      prod_y = tgr_pkg::PROD_W'(ay) * tgr_pkg::PROD_W'(tgr_pkg::MUL_Y);
      prod_x = tgr_pkg::PROD_W'(ax) * tgr_pkg::PROD_W'(tgr_pkg::MUL_X);
      q_y    = prod_y[tgr_pkg::RECIP_SHIFT +: tgr_pkg::Q_W];
      q_x    = prod_x[tgr_pkg::RECIP_SHIFT +: tgr_pkg::Q_W];
      y_full = tgr_pkg::Q_W'(tgr_pkg::MAX_Y) - q_y;

      smp_in.touching = pressure_ff > cfg.pressure_threshold;
      smp_in.time_ms  = time_ff;

      if (raw_x_ff < tgr_pkg::RAW_W'(tgr_pkg::RAW_X0)) begin
         smp_in.y = tgr_pkg::Y_W'(tgr_pkg::MAX_Y);
      end else if (q_y > tgr_pkg::Q_W'(tgr_pkg::MAX_Y)) begin
         smp_in.y = '0;
      end else begin
         smp_in.y = y_full[tgr_pkg::Y_W-1:0];
      end

      if (raw_y_ff < tgr_pkg::RAW_W'(tgr_pkg::RAW_Y0)) begin
         smp_in.x = '0;
      end else if (q_x > tgr_pkg::Q_W'(tgr_pkg::MAX_X)) begin
         smp_in.x = tgr_pkg::X_W'(tgr_pkg::MAX_X);
      end else begin
         smp_in.x = q_x[tgr_pkg::X_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
      end
      if (req_valid && req_ready) begin
         pressure_ff <= req_pressure;
         raw_x_ff    <= req_raw_x;
         raw_y_ff    <= req_raw_y;
         time_ff     <= req_time_ms;
      end
      if (s2_load && s1_valid_ff) begin
         smp_ff <= smp_in;
      end
   end

   assign smp_valid = s2_valid_ff;
   assign smp       = smp_ff;

endmodule

[rtl/core/tgr_track.sv]
// Gesture tracker: press state, gesture flags and timers, plus the result
// register. Depends on tgr_pkg.
module tgr_track (
   input  logic                          clock,
   input  logic                          reset,
   input  tgr_pkg::tgr_cfg_type          cfg,
   input  logic                          smp_valid,
   output logic                          smp_ready,
   input  tgr_pkg::tgr_sample_type       smp,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_touching,
   output logic [3:0]                    rsp_gesture,
   output logic [tgr_pkg::X_W-1:0]       rsp_start_x,
   output logic [tgr_pkg::Y_W-1:0]       rsp_start_y,
   output logic [tgr_pkg::X_W-1:0]       rsp_end_x,
   output logic [tgr_pkg::Y_W-1:0]       rsp_end_y
);

   logic                          is_pressed_ff, is_pressed_in;
   logic                          long_flag_ff, long_flag_in;
   logic                          drag_flag_ff, drag_flag_in;
   logic                          double_flag_ff, double_flag_in;
   logic [tgr_pkg::X_W-1:0]       press_x_ff, press_x_in;
   logic [tgr_pkg::Y_W-1:0]       press_y_ff, press_y_in;
   logic [tgr_pkg::X_W-1:0]       last_x_ff, last_x_in;
   logic [tgr_pkg::Y_W-1:0]       last_y_ff, last_y_in;
   logic [tgr_pkg::TIME_W-1:0]    last_time_ff, last_time_in;
   logic [tgr_pkg::TIME_W-1:0]    ref_time_ff, ref_time_in;

   logic                          rsp_valid_ff;
   logic                          touching_ff;
   tgr_pkg::tgr_gesture_type      gesture_ff, gesture_in;
   logic [tgr_pkg::X_W-1:0]       sx_ff, sx_in, ex_ff, ex_in;
   logic [tgr_pkg::Y_W-1:0]       sy_ff, sy_in, ey_ff, ey_in;

   logic [tgr_pkg::TIME_W-1:0]    dt_last;
   logic [tgr_pkg::TIME_W-1:0]    dt_ref;
   logic [tgr_pkg::X_W-1:0]       dx;
   logic [tgr_pkg::Y_W-1:0]       dy;
   logic                          advance;
   logic                          is_release;

   assign smp_ready = !rsp_valid_ff || rsp_ready;
   assign advance   = smp_valid && smp_ready;

   always_comb begin
      is_pressed_in  = is_pressed_ff;
      long_flag_in   = long_flag_ff;
      drag_flag_in   = drag_flag_ff;
      double_flag_in = double_flag_ff;
      press_x_in     = press_x_ff;
      press_y_in     = press_y_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      last_time_in   = last_time_ff;
      ref_time_in    = ref_time_ff;
      gesture_in     = tgr_pkg::G_NONE;
      sx_in          = '0;
      sy_in          = '0;
      ex_in          = '0;
      ey_in          = '0;
      is_release     = 1'b0;

      dt_last = smp.time_ms - last_time_ff;
      dt_ref  = smp.time_ms - ref_time_ff;
      dx = (smp.x > press_x_ff) ? smp.x - press_x_ff : press_x_ff - smp.x;
      dy = (smp.y > press_y_ff) ? smp.y - press_y_ff : press_y_ff - smp.y;

      if (smp.touching) begin
         last_x_in    = smp.x;
         last_y_in    = smp.y;
         last_time_in = smp.time_ms;
         if (!is_pressed_ff) begin
            long_flag_in  = 1'b0;
            drag_flag_in  = 1'b0;
            is_pressed_in = 1'b1;
            press_x_in    = smp.x;
            press_y_in    = smp.y;
            if (dt_last < tgr_pkg::TIME_W'(cfg.double_tap_ms)) begin
               double_flag_in = 1'b1;
               gesture_in     = tgr_pkg::G_DOUBLE_PRESS;
            end else begin
               ref_time_in = smp.time_ms;
               gesture_in  = tgr_pkg::G_PRESS;
            end
         end else if (dx > cfg.drag_distance ||
                      tgr_pkg::DRAG_W'(dy) > cfg.drag_distance) begin
            drag_flag_in = 1'b1;
            ref_time_in  = smp.time_ms;
            if (double_flag_ff) begin
               gesture_in = tgr_pkg::G_TAP_DRAG;
            end else if (long_flag_ff) begin
               gesture_in = tgr_pkg::G_LONG_DRAG;
            end else begin
               gesture_in = tgr_pkg::G_DRAG;
            end
         end else if (dt_ref > tgr_pkg::TIME_W'(cfg.long_press_ms) &&
                      !long_flag_ff && !drag_flag_ff) begin
            long_flag_in = 1'b1;
            ref_time_in  = smp.time_ms;
            gesture_in   = double_flag_ff ? tgr_pkg::G_TAP_LONG : tgr_pkg::G_LONG_PRESS;
         end
         if (gesture_in != tgr_pkg::G_NONE) begin
            sx_in = press_x_in;
            sy_in = press_y_in;
            ex_in = smp.x;
            ey_in = smp.y;
         end
      end else if (is_pressed_ff &&
                   dt_last > tgr_pkg::TIME_W'(cfg.release_delay_ms)) begin
         is_release = 1'b1;
         if (double_flag_ff) begin
            if (drag_flag_ff) begin
               gesture_in = tgr_pkg::G_TAP_DRAG_REL;
            end else if (long_flag_ff) begin
               gesture_in = tgr_pkg::G_TAP_LONG_REL;
            end else begin
               gesture_in = tgr_pkg::G_DOUBLE_TAPPED;
            end
         end else if (drag_flag_ff) begin
            gesture_in = long_flag_ff ? tgr_pkg::G_LONG_DRAG_REL : tgr_pkg::G_DRAG_REL;
         end else begin
            gesture_in = long_flag_ff ? tgr_pkg::G_LONG_REL : tgr_pkg::G_TAPPED;
         end
         sx_in          = press_x_ff;
         sy_in          = press_y_ff;
         ex_in          = last_x_ff;
         ey_in          = last_y_ff;
         is_pressed_in  = 1'b0;
         long_flag_in   = 1'b0;
         drag_flag_in   = 1'b0;
         double_flag_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_pressed_ff  <= 1'b0;
         long_flag_ff   <= 1'b0;
         drag_flag_ff   <= 1'b0;
         double_flag_ff <= 1'b0;
         press_x_ff     <= '0;
         press_y_ff     <= '0;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         last_time_ff   <= '0;
         ref_time_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (smp_ready) begin
            rsp_valid_ff <= smp_valid;
         end
         if (advance) begin
            is_pressed_ff  <= is_pressed_in;
            long_flag_ff   <= long_flag_in;
            drag_flag_ff   <= drag_flag_in;
            double_flag_ff <= double_flag_in;
            press_x_ff     <= press_x_in;
            press_y_ff     <= press_y_in;
            last_x_ff      <= last_x_in;
            last_y_ff      <= last_y_in;
            last_time_ff   <= last_time_in;
            ref_time_ff    <= ref_time_in;
         end
      end
      if (advance) begin
         touching_ff <= smp.touching;
         gesture_ff  <= gesture_in;
         sx_ff       <= sx_in;
         sy_ff       <= sy_in;
         ex_ff       <= ex_in;
         ey_ff       <= ey_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_touching = touching_ff;
   assign rsp_gesture  = gesture_ff;
   assign rsp_start_x  = sx_ff;
   assign rsp_start_y  = sy_ff;
   assign rsp_end_x    = ex_ff;
   assign rsp_end_y    = ey_ff;

   a_none_no_points: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_gesture == tgr_pkg::G_NONE |->
         rsp_start_x == '0 && rsp_start_y == '0 && rsp_end_x == '0 && rsp_end_y == '0)
      else $error("no-event result carries nonzero points");

   a_idle_only_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_touching |->
         rsp_gesture == tgr_pkg::G_NONE || rsp_gesture >= tgr_pkg::G_TAPPED)
      else $error("non-touching sample produced a press-type gesture");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      advance && is_release |=> !is_pressed_ff && !long_flag_ff &&
         !drag_flag_ff && !double_flag_ff)
      else $error("release left press state behind");

   a_flags_need_press: assert property (@(posedge clock) disable iff (reset)
      long_flag_ff || drag_flag_ff || double_flag_ff |-> is_pressed_ff)
      else $error("gesture flag set while not pressed");

endmodule

[rtl/core/touch_gesture_recognizer.sv]
// Top level of the touch gesture recognizer: configuration registers and the
// two-stage sample pipeline. Depends on tgr_pkg, tgr_scale and tgr_track.
//
// Each accepted req item is one resistive touch sample (pressure, raw x and
// y readings, millisecond timestamp) and yields exactly one rsp item: the
// touch flag, a gesture code (0 none, 1 press ... 14 tap+long released) and
// the start and end screen points of the gesture, all zero when no event.
// The block takes one item every cycle while rsp is not stalled. The first
// stage registers an accepted sample, scales it to a clamped 320x240 screen
// point with one constant multiply per axis and registers that point; the
// second stage updates the press state and timers and loads the result
// register. Backpressure on rsp stalls both stages together; a free result
// register or stage lets req keep flowing. Timestamps compare modulo 2^32.
// Write the csr registers (index 0 pressure threshold, 1 release delay,
// 2 long press time, 3 double tap window, 4 drag distance) only while no item
// is in flight; indexes above 4 are ignored and wide data is truncated.
module touch_gesture_recognizer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [tgr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tgr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tgr_pkg::RAW_W-1:0]        req_pressure,
   input  logic [tgr_pkg::RAW_W-1:0]        req_raw_x,
   input  logic [tgr_pkg::RAW_W-1:0]        req_raw_y,
   input  logic [tgr_pkg::TIME_W-1:0]       req_time_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_touching,
   output logic [3:0]                       rsp_gesture,
   output logic [tgr_pkg::X_W-1:0]          rsp_start_x,
   output logic [tgr_pkg::Y_W-1:0]          rsp_start_y,
   output logic [tgr_pkg::X_W-1:0]          rsp_end_x,
   output logic [tgr_pkg::Y_W-1:0]          rsp_end_y
);

   tgr_pkg::tgr_cfg_type     cfg_ff;
   tgr_pkg::tgr_sample_type  smp;
   logic                     smp_valid;
   logic                     smp_ready;

   // Configuration registers; reset to the documented defaults
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pressure_threshold <= tgr_pkg::RAW_W'(10);
         cfg_ff.release_delay_ms   <= tgr_pkg::MS_W'(300);
         cfg_ff.long_press_ms      <= tgr_pkg::MS_W'(500);
         cfg_ff.double_tap_ms      <= tgr_pkg::MS_W'(700);
         cfg_ff.drag_distance      <= tgr_pkg::DRAG_W'(20);
      end else if (csr_we) begin
         case (csr_index)
            tgr_pkg::CSR_PRESSURE_THRESHOLD: begin
               cfg_ff.pressure_threshold <= csr_wdata[tgr_pkg::RAW_W-1:0];
            end
            tgr_pkg::CSR_RELEASE_DELAY: begin
               cfg_ff.release_delay_ms <= csr_wdata;
            end
            tgr_pkg::CSR_LONG_PRESS: begin
               cfg_ff.long_press_ms <= csr_wdata;
            end
            tgr_pkg::CSR_DOUBLE_TAP: begin
               cfg_ff.double_tap_ms <= csr_wdata;
            end
            tgr_pkg::CSR_DRAG_DISTANCE: begin
               cfg_ff.drag_distance <= csr_wdata[tgr_pkg::DRAG_W-1:0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Stage 1: hold the sample, scale and clamp it, decide touch
   tgr_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pressure (req_pressure),
      .req_raw_x    (req_raw_x),
      .req_raw_y    (req_raw_y),
      .req_time_ms  (req_time_ms),
      .smp_valid    (smp_valid),
      .smp_ready    (smp_ready),
      .smp          (smp)
   );

   // Stage 2: advance the gesture state and register the result item
   tgr_track u_track (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .smp_valid    (smp_valid),
      .smp_ready    (smp_ready),
      .smp          (smp),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_touching (rsp_touching),
      .rsp_gesture  (rsp_gesture),
      .rsp_start_x  (rsp_start_x),
      .rsp_start_y  (rsp_start_y),
      .rsp_end_x    (rsp_end_x),
      .rsp_end_y    (rsp_end_y)
   );

endmodule
